// ===== hw/rtl/omsu_pkg.sv =====
// ----------------------------------------------------------------------------
// omsu_pkg
// Shared types, constants and the arctangent table of the odometry motion
// sample unit.
// ----------------------------------------------------------------------------
package omsu_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CS_N          = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    localparam logic [29:0] K_Q30          = 30'd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;

    typedef enum logic [2:0] {
        CFG_A1        = 3'd0,
        CFG_A2        = 3'd1,
        CFG_A3        = 3'd2,
        CFG_A4        = 3'd3,
        CFG_MIN_TRANS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] a1;
        logic [23:0] a2;
        logic [23:0] a3;
        logic [23:0] a4;
        logic [15:0] min_trans;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [15:0]        head;
        logic [15:0]        dhead;
        logic signed [15:0] n1;
        logic signed [15:0] nt;
        logic signed [15:0] n2;
    } t_side;

    typedef struct packed {
        logic signed [47:0] trans_s;
        logic [31:0]        hsum;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_rcar;

    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/odometry_motion_sample_unit.sv =====
// ----------------------------------------------------------------------------
// odometry_motion_sample_unit
// Moves one particle per request by the sampled odometry motion model.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a particle pose, the odometry
// delta and three standard-normal noise samples. Output channel: o_out_valid
// / i_out_stall carry the moved pose. A request is taken on a clock edge with
// valid high and stall low.
// Throughput: one request per clock while the receiver does not stall. Each
// CORDIC pipeline has one stage per iteration.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_stall rises; nothing is dropped or repeated.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0..3 alphas, 4 minimum translation); write only while the unit is empty.
// Reset (synchronous, active low) empties the pipeline and loads alphas of 0
// and a minimum translation of 7.
// ----------------------------------------------------------------------------
module odometry_motion_sample_unit
    import omsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    input  logic signed [31:0] i_delta_x,
    input  logic signed [31:0] i_delta_y,
    input  logic signed [15:0] i_delta_heading,
    input  logic signed [15:0] i_noise_first_turn,
    input  logic signed [15:0] i_noise_travel,
    input  logic signed [15:0] i_noise_second_turn,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [15:0] o_new_heading,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    t_cfg  r_cfg;
    logic  n_en;
    t_side n_side;

    logic        vec_valid;
    logic [32:0] vec_trans;
    logic [31:0] vec_ang;
    t_side       vec_side;

    logic        dev_valid;
    logic [31:0] dev_phi;
    t_rcar       dev_car;

    logic               rot_valid;
    logic signed [33:0] rot_cos, rot_sin;
    t_rcar              rot_car;

    assign n_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{a1: 24'd0, a2: 24'd0, a3: 24'd0, a4: 24'd0, min_trans: 16'd7};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_A1:        r_cfg.a1        <= i_cfg_data;
                CFG_A2:        r_cfg.a2        <= i_cfg_data;
                CFG_A3:        r_cfg.a3        <= i_cfg_data;
                CFG_A4:        r_cfg.a4        <= i_cfg_data;
                CFG_MIN_TRANS: r_cfg.min_trans <= i_cfg_data[15:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_comb begin
        n_side.pose_x = i_pose_x;
        n_side.pose_y = i_pose_y;
        n_side.head   = i_pose_heading;
        n_side.dhead  = i_delta_heading;
        n_side.n1     = i_noise_first_turn;
        n_side.nt     = i_noise_travel;
        n_side.n2     = i_noise_second_turn;
    end

    omsu_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_in_valid),
        .i_dx    (i_delta_x),
        .i_dy    (i_delta_y),
        .i_side  (n_side),
        .o_valid (vec_valid),
        .o_trans (vec_trans),
        .o_ang   (vec_ang),
        .o_side  (vec_side)
    );

    omsu_dev u_dev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_cfg   (r_cfg),
        .i_valid (vec_valid),
        .i_trans (vec_trans),
        .i_ang   (vec_ang),
        .i_side  (vec_side),
        .o_valid (dev_valid),
        .o_phi   (dev_phi),
        .o_car   (dev_car)
    );

    omsu_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (dev_valid),
        .i_phi   (dev_phi),
        .i_car   (dev_car),
        .o_valid (rot_valid),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin),
        .o_car   (rot_car)
    );

    omsu_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (n_en),
        .i_valid       (rot_valid),
        .i_cos         (rot_cos),
        .i_sin         (rot_sin),
        .i_car         (rot_car),
        .o_valid       (o_out_valid),
        .o_new_x       (o_new_x),
        .o_new_y       (o_new_y),
        .o_new_heading (o_new_heading)
    );

endmodule

// ===== hw/rtl/omsu_vec.sv =====
// ----------------------------------------------------------------------------
// omsu_vec
// Vectoring CORDIC pipeline: magnitude and angle of the odometry delta.
// ----------------------------------------------------------------------------
module omsu_vec
    import omsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_dx,
    input  logic signed [31:0] i_dy,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [32:0]        o_trans,
    output logic [31:0]        o_ang,
    output t_side              o_side
);

    localparam int VW = 36;

    logic               r_v  [0:CS_N];
    logic signed [VW-1:0] r_x [0:CS_N];
    logic signed [VW-1:0] r_y [0:CS_N];
    logic [31:0]        r_z  [0:CS_N];
    t_side              r_sd [0:CS_N];

    logic signed [VW-1:0] n_x0, n_y0;
    logic [31:0]        n_z0;

    always_comb begin
        if (i_dx[31]) begin
            n_x0 = -{{(VW-32){i_dx[31]}}, i_dx};
            n_y0 = -{{(VW-32){i_dy[31]}}, i_dy};
            n_z0 = 32'h80000000;
        end else begin
            n_x0 = {{(VW-32){i_dx[31]}}, i_dx};
            n_y0 = {{(VW-32){i_dy[31]}}, i_dy};
            n_z0 = 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_sd[0] <= i_side;
        end
    end

    for (genvar k = 0; k < CS_N; k++) begin : g_it
        logic signed [VW-1:0] n_x, n_y;
        logic [31:0]          n_z;

        always_comb begin
            if (!r_y[k][VW-1]) begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + atan_at(k);
            end else begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - atan_at(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]  <= n_x;
                r_y[k+1]  <= n_y;
                r_z[k+1]  <= n_z;
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    // gain correction
    logic        r_vm1, r_vm2;
    logic [64:0] r_prod;
    logic [31:0] r_ang1, r_ang2;
    t_side       r_sd1, r_sd2;
    logic [32:0] r_trans;
    logic [64:0] n_rnd;

    assign n_rnd = r_prod + 65'd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
        end else if (i_en) begin
            r_vm1 <= r_v[CS_N];
            r_vm2 <= r_vm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= {30'd0, r_x[CS_N][34:0]} * {35'd0, K_Q30};
            r_ang1  <= r_z[CS_N];
            r_sd1   <= r_sd[CS_N];
            r_trans <= n_rnd[62:30];
            r_ang2  <= r_ang1;
            r_sd2   <= r_sd1;
        end
    end

    assign o_valid = r_vm2;
    assign o_trans = r_trans;
    assign o_ang   = r_ang2;
    assign o_side  = r_sd2;

endmodule

// ===== hw/rtl/omsu_dev.sv =====
// ----------------------------------------------------------------------------
// omsu_dev
// Motion split, noise deviations and perturbed motion terms.
// ----------------------------------------------------------------------------
module omsu_dev
    import omsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [32:0] i_trans,
    input  logic [31:0] i_ang,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_phi,
    output t_rcar       o_car
);

    typedef struct packed {
        logic [32:0] trans;
        logic [31:0] rot1;
        logic [31:0] rot2;
    } t_dcar;

    logic [8:0] r_vp;
    t_side      r_sd [1:9];
    t_dcar      r_cr [1:7];

    // D2
    logic [31:0] r_ab1, r_ab2;
    logic [32:0] r_absum;
    // D3
    logic [55:0] r_p_r1, r_p_r2;
    logic [56:0] r_p_a2t, r_p_a3t, r_p_a4r;
    // D4
    logic [54:0] r_a2h;
    logic [61:0] r_a2l;
    logic [56:0] r_a4h;
    logic [63:0] r_a4l;
    logic [39:0] r_sr1b, r_sr2b;
    logic [40:0] r_stb;
    // D5
    logic [39:0] r_sr1c, r_sr2c;
    logic [40:0] r_stc;
    logic [54:0] r_a2t;
    logic [28:0] r_a4t;
    // D6
    logic [43:0] r_sr1, r_sr2;
    logic [41:0] r_st;
    // D7
    logic [31:0] r_dev1, r_dev2;
    logic signed [46:0] r_devt;
    // D8
    logic [31:0] r_r1s, r_r2s;
    logic signed [47:0] r_trans_s;
    // D9
    logic [31:0] r_phi, r_hsum;
    logic signed [47:0] r_trans_s9;

    logic [31:0] n_rot1, n_rot2;
    logic [31:0] n_ab1, n_ab2;
    logic [57:0] n_a4sum;
    logic [39:0] n_sr1, n_sr2;
    logic signed [60:0] n_q1, n_q2;
    logic signed [58:0] n_qt;
    logic [31:0] n_head;

    always_comb begin
        n_rot1  = (i_trans > {17'd0, i_cfg.min_trans}) ? i_ang : 32'h0;
        n_rot2  = {i_side.dhead, 16'h0} - n_rot1;
        n_ab1   = r_cr[1].rot1[31] ? (32'h0 - r_cr[1].rot1) : r_cr[1].rot1;
        n_ab2   = r_cr[1].rot2[31] ? (32'h0 - r_cr[1].rot2) : r_cr[1].rot2;
        n_a4sum = {1'b0, r_a4h} + {26'd0, r_a4l[63:32]};
        n_sr1   = r_sr1c + r_a2t[39:0];
        n_sr2   = r_sr2c + r_a2t[39:0];
        n_q1    = 61'(r_sd[6].n1) * 61'($signed({1'b0, r_sr1}));
        n_q2    = 61'(r_sd[6].n2) * 61'($signed({1'b0, r_sr2}));
        n_qt    = 59'(r_sd[6].nt) * 59'($signed({1'b0, r_st}));
        n_head  = {r_sd[8].head, 16'h0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (i_en) begin
            r_vp <= {r_vp[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[1] <= i_side;
            for (int k = 2; k <= 9; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_cr[1] <= '{trans: i_trans, rot1: n_rot1, rot2: n_rot2};
            for (int k = 2; k <= 7; k++) begin
                r_cr[k] <= r_cr[k-1];
            end
            // D2
            r_ab1   <= n_ab1;
            r_ab2   <= n_ab2;
            r_absum <= {1'b0, n_ab1} + {1'b0, n_ab2};
            // D3
            r_p_r1  <= {32'd0, i_cfg.a1} * {24'd0, r_ab1};
            r_p_r2  <= {32'd0, i_cfg.a1} * {24'd0, r_ab2};
            r_p_a2t <= {33'd0, i_cfg.a2} * {24'd0, r_cr[2].trans};
            r_p_a3t <= {33'd0, i_cfg.a3} * {24'd0, r_cr[2].trans};
            r_p_a4r <= {33'd0, i_cfg.a4} * {24'd0, r_absum};
            // D4
            r_a2h  <= {30'd0, r_p_a2t[56:32]} * {25'd0, INV_TWO_PI_Q32};
            r_a2l  <= {30'd0, r_p_a2t[31:0]} * {32'd0, INV_TWO_PI_Q32};
            r_a4h  <= {32'd0, r_p_a4r[56:32]} * {25'd0, TWO_PI_Q29};
            r_a4l  <= {32'd0, r_p_a4r[31:0]} * {32'd0, TWO_PI_Q29};
            r_sr1b <= r_p_r1[55:16];
            r_sr2b <= r_p_r2[55:16];
            r_stb  <= r_p_a3t[56:16];
            // D5
            r_a2t  <= r_a2h + {25'd0, r_a2l[61:32]};
            r_a4t  <= n_a4sum[57:29];
            r_sr1c <= r_sr1b;
            r_sr2c <= r_sr2b;
            r_stc  <= r_stb;
            // D6: rotation deviations only need their low 44 bits
            r_sr1[43:40] <= r_a2t[43:40] + 4'(({1'b0, r_sr1c} +
                                                {1'b0, r_a2t[39:0]}) >> 40);
            r_sr1[39:0]  <= n_sr1;
            r_sr2[43:40] <= r_a2t[43:40] + 4'(({1'b0, r_sr2c} +
                                                {1'b0, r_a2t[39:0]}) >> 40);
            r_sr2[39:0]  <= n_sr2;
            r_st   <= {1'b0, r_stc} + {13'd0, r_a4t};
            // D7
            r_dev1 <= n_q1[43:12];
            r_dev2 <= n_q2[43:12];
            r_devt <= n_qt[58:12];
            // D8
            r_r1s     <= r_cr[7].rot1 + r_dev1;
            r_r2s     <= r_cr[7].rot2 + r_dev2;
            r_trans_s <= $signed({15'd0, r_cr[7].trans}) + 48'(r_devt);
            // D9
            r_phi      <= n_head + r_r1s;
            r_hsum     <= n_head + r_r1s + r_r2s;
            r_trans_s9 <= r_trans_s;
        end
    end

    assign o_valid       = r_vp[8];
    assign o_phi         = r_phi;
    assign o_car.trans_s = r_trans_s9;
    assign o_car.hsum    = r_hsum;
    assign o_car.px      = r_sd[9].pose_x;
    assign o_car.py      = r_sd[9].pose_y;

endmodule

// ===== hw/rtl/omsu_rot.sv =====
// ----------------------------------------------------------------------------
// omsu_rot
// Rotation CORDIC pipeline: cosine and sine of the travel direction.
// ----------------------------------------------------------------------------
module omsu_rot
    import omsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_phi,
    input  t_rcar              i_car,
    output logic               o_valid,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin,
    output t_rcar              o_car
);

    localparam int RW = 34;

    logic                 r_v  [0:CS_N+1];
    logic signed [RW-1:0] r_x  [0:CS_N];
    logic signed [RW-1:0] r_y  [0:CS_N];
    logic signed [RW-1:0] r_z  [0:CS_N];
    logic                 r_fl [0:CS_N];
    t_rcar                r_cr [0:CS_N+1];
    logic signed [RW-1:0] r_cos, r_sin;

    logic signed [RW-1:0] n_z0, n_zs;
    logic                 n_fl0;

    always_comb begin
        n_zs  = {{(RW-32){i_phi[31]}}, i_phi};
        n_z0  = n_zs;
        n_fl0 = 1'b0;
        if (n_zs > 34'sd1073741824) begin
            n_z0  = n_zs - 34'sd2147483648;
            n_fl0 = 1'b1;
        end else if (n_zs < -34'sd1073741824) begin
            n_z0  = n_zs + 34'sd2147483648;
            n_fl0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= $signed({4'd0, K_Q30});
            r_y[0]  <= '0;
            r_z[0]  <= n_z0;
            r_fl[0] <= n_fl0;
            r_cr[0] <= i_car;
        end
    end

    for (genvar k = 0; k < CS_N; k++) begin : g_it
        logic signed [RW-1:0] n_x, n_y, n_z, n_at;

        always_comb begin
            n_at = $signed({2'd0, atan_at(k)});
            if (!r_z[k][RW-1]) begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - n_at;
            end else begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + n_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]  <= n_x;
                r_y[k+1]  <= n_y;
                r_z[k+1]  <= n_z;
                r_fl[k+1] <= r_fl[k];
                r_cr[k+1] <= r_cr[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[CS_N+1] <= 1'b0;
        end else if (i_en) begin
            r_v[CS_N+1] <= r_v[CS_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos        <= r_fl[CS_N] ? -r_x[CS_N] : r_x[CS_N];
            r_sin        <= r_fl[CS_N] ? -r_y[CS_N] : r_y[CS_N];
            r_cr[CS_N+1] <= r_cr[CS_N];
        end
    end

    assign o_valid = r_v[CS_N+1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_car   = r_cr[CS_N+1];

endmodule

// ===== hw/rtl/omsu_out.sv =====
// ----------------------------------------------------------------------------
// omsu_out
// Displacement products, saturating position update and heading rounding.
// ----------------------------------------------------------------------------
module omsu_out
    import omsu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [33:0] i_cos,
    input  logic signed [33:0] i_sin,
    input  t_rcar              i_car,
    output logic               o_valid,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [15:0] o_new_heading
);

    logic [3:0] r_vp;

    // O1
    logic [46:0] r_at;
    logic [31:0] r_ac, r_as;
    logic        r_negc1, r_negs1;
    logic [15:0] r_hd [1:4];
    logic signed [31:0] r_px [1:3];
    logic signed [31:0] r_py [1:3];
    // O2
    logic [46:0] r_hc, r_hs;
    logic [63:0] r_lc, r_ls;
    logic        r_negc2, r_negs2;
    // O3
    logic signed [49:0] r_dc, r_ds;
    // O4
    logic signed [31:0] r_nx, r_ny;

    logic signed [47:0] n_tabs;
    logic signed [33:0] n_cabs, n_sabs;
    logic [31:0]        n_hr;
    logic [48:0]        n_mc, n_ms;
    logic signed [50:0] n_sx, n_sy;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_comb begin
        n_tabs = i_car.trans_s[47] ? -i_car.trans_s : i_car.trans_s;
        n_cabs = i_cos[33] ? -i_cos : i_cos;
        n_sabs = i_sin[33] ? -i_sin : i_sin;
        n_hr   = i_car.hsum + 32'h8000;
        n_mc   = {r_hc, 2'b00} + {15'd0, r_lc[63:30]};
        n_ms   = {r_hs, 2'b00} + {15'd0, r_ls[63:30]};
        n_sx   = 51'(r_px[3]) + 51'(r_dc);
        n_sy   = 51'(r_py[3]) + 51'(r_ds);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (i_en) begin
            r_vp <= {r_vp[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // O1
            r_at    <= n_tabs[46:0];
            r_ac    <= n_cabs[31:0];
            r_as    <= n_sabs[31:0];
            r_negc1 <= i_car.trans_s[47] ^ i_cos[33];
            r_negs1 <= i_car.trans_s[47] ^ i_sin[33];
            r_hd[1] <= n_hr[31:16];
            r_px[1] <= i_car.px;
            r_py[1] <= i_car.py;
            // O2
            r_hc    <= {32'd0, r_at[46:32]} * {15'd0, r_ac};
            r_lc    <= {32'd0, r_at[31:0]} * {32'd0, r_ac};
            r_hs    <= {32'd0, r_at[46:32]} * {15'd0, r_as};
            r_ls    <= {32'd0, r_at[31:0]} * {32'd0, r_as};
            r_negc2 <= r_negc1;
            r_negs2 <= r_negs1;
            r_hd[2] <= r_hd[1];
            r_px[2] <= r_px[1];
            r_py[2] <= r_py[1];
            // O3
            r_dc    <= r_negc2 ? -$signed({1'b0, n_mc}) : $signed({1'b0, n_mc});
            r_ds    <= r_negs2 ? -$signed({1'b0, n_ms}) : $signed({1'b0, n_ms});
            r_hd[3] <= r_hd[2];
            r_px[3] <= r_px[2];
            r_py[3] <= r_py[2];
            // O4
            r_nx    <= sat32(n_sx);
            r_ny    <= sat32(n_sy);
            r_hd[4] <= r_hd[3];
        end
    end

    assign o_valid       = r_vp[3];
    assign o_new_x       = r_nx;
    assign o_new_y       = r_ny;
    assign o_new_heading = $signed(r_hd[4]);

endmodule
